// ===== hdl/bdiv_pkg.sv =====
// Shared constants and pipeline types for the binary64 divider.
package bdiv_pkg;

  localparam int FracW = 52;
  localparam int ExpW = 11;
  localparam int SigW = 53;
  localparam int QuoW = 63;
  localparam int ExpIW = 13;  // signed working exponent

  localparam logic [63:0] QNAN_CANON = 64'h7FF8000000000000;
  localparam logic [ExpW-1:0] EXP_ONES = 11'h7FF;
  localparam logic signed [ExpIW-1:0] EXP_BIAS_M1 = 13'sh3FE;
  localparam logic signed [ExpIW-1:0] EXP_TOP = 13'sh7FD;
  localparam logic [9:0] HALF_LSB = 10'h200;

  localparam int BitsPerStageDef = 4;

  // Item state while the quotient bits are developed
  typedef struct packed {
    logic               special;
    logic [63:0]        spec_val;
    logic               sgn;
    logic signed [ExpIW-1:0] ez;
    logic [SigW:0]      rem;
    logic [SigW-1:0]    mb;
    logic [QuoW-1:0]    q;
  } div_item_t;

  // Leading-zero count of a 53-bit value (bit 52 is the top)
  function automatic logic [5:0] lzc53(input logic [SigW-1:0] v);
    logic [5:0] n;
    logic found;
    n = 6'd0;
    found = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 6'(SigW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/bdiv_if.sv =====
// Valid/ready channel interface carrying a 64-bit-wide payload.
interface bdiv_if #(
  parameter int W = 64
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/bdiv_in_if.sv =====
// Valid/ready channel interface carrying one dividend/divisor beat.
interface bdiv_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] dividend;
  logic [63:0] divisor;
  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

// ===== hdl/bdiv_stage.sv =====
// One restoring-division stage: develops Bits quotient bits per cycle while en is high.
module bdiv_stage #(
  parameter int Bits = bdiv_pkg::BitsPerStageDef
) (
  input  logic                clk,
  input  logic                en,
  input  logic                vld_in,
  input  bdiv_pkg::div_item_t d_in,
  output logic                vld_out_nxt,
  output bdiv_pkg::div_item_t d_out_r
);
  import bdiv_pkg::*;

  div_item_t nx;

  // Shift-subtract steps on the partial remainder
  always_comb begin
    logic [SigW:0] diff;
    nx = d_in;
    for (int k = 0; k < Bits; k++) begin
      diff = nx.rem - {1'b0, nx.mb};
      nx.q = {nx.q[QuoW-2:0], !diff[SigW]};
      if (!diff[SigW]) nx.rem = diff;
      nx.rem = {nx.rem[SigW-1:0], 1'b0};
    end
  end

  assign vld_out_nxt = vld_in;

  always_ff @(posedge clk) begin
    if (en) d_out_r <= nx;
  end
endmodule

// ===== hdl/binary64_divider.sv =====
// Pipelined IEEE 754 binary64 divider, round to nearest even.
//
//  channel | dir | beat payload
//  in_     | in  | dividend[63:0], divisor[63:0]
//  out_    | out | quotient[63:0]
//
// Throughput one beat per cycle while out_ is not stalled; each beat is registered
// at stage 0, in every division stage and in the final rounding stage.
// Reset clears only valid bits. A stall on out_ freezes the whole pipe, so
// nothing is lost or repeated; in_ready follows out_ready or a free slot.
module binary64_divider #(
  parameter int BitsPerStage = bdiv_pkg::BitsPerStageDef
) (
  input  logic        clk,
  input  logic        rst_n,
  bdiv_in_if.sink     in_ch,
  bdiv_if.source      out_ch
);
  import bdiv_pkg::*;

  localparam int NStg = (QuoW + BitsPerStage - 1) / BitsPerStage;

  logic en;
  logic in_fire;

  // Pipeline moves when the output slot is free or being taken
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign in_fire = in_ch.valid && en;

  // ---- stage 0: unpack, specials, normalize ----
  div_item_t s0_nxt, s0_r;
  logic      s0_vld_r;

  always_comb begin
    logic [ExpW-1:0] ea, eb;
    logic [FracW-1:0] fa, fb;
    logic [SigW-1:0] ma, mb;
    logic [5:0] la, lb;
    logic signed [ExpIW-1:0] xa, xb, ez;
    logic sgn;
    ea = in_ch.dividend[62:52];
    eb = in_ch.divisor[62:52];
    fa = in_ch.dividend[51:0];
    fb = in_ch.divisor[51:0];
    sgn = in_ch.dividend[63] ^ in_ch.divisor[63];
    s0_nxt = '0;
    s0_nxt.sgn = sgn;
    // normalize operands (subnormals by leading-zero count)
    if (ea == '0) begin
      la = lzc53({1'b0, fa});
      ma = {1'b0, fa} << la;
      xa = ExpIW'(13'sd1) - ExpIW'($signed({1'b0, la}));
    end else begin
      la = '0;
      ma = {1'b1, fa};
      xa = ExpIW'($signed({2'b0, ea}));
    end
    if (eb == '0) begin
      lb = lzc53({1'b0, fb});
      mb = {1'b0, fb} << lb;
      xb = ExpIW'(13'sd1) - ExpIW'($signed({1'b0, lb}));
    end else begin
      lb = '0;
      mb = {1'b1, fb};
      xb = ExpIW'($signed({2'b0, eb}));
    end
    ez = xa - xb + EXP_BIAS_M1;
    s0_nxt.mb = mb;
    if (ma < mb) begin
      s0_nxt.ez = ez - 13'sd1;
      s0_nxt.rem = {ma, 1'b0};
    end else begin
      s0_nxt.ez = ez;
      s0_nxt.rem = {1'b0, ma};
    end
    // special operands
    if (ea == EXP_ONES) begin
      s0_nxt.special = 1'b1;
      s0_nxt.spec_val = (fa != '0 || eb == EXP_ONES) ? QNAN_CANON
                        : {sgn, EXP_ONES, 52'd0};
    end else if (eb == EXP_ONES) begin
      s0_nxt.special = 1'b1;
      s0_nxt.spec_val = (fb != '0) ? QNAN_CANON : {sgn, 63'd0};
    end else if (eb == '0 && fb == '0) begin
      s0_nxt.special = 1'b1;
      s0_nxt.spec_val = (ea == '0 && fa == '0) ? QNAN_CANON
                        : {sgn, EXP_ONES, 52'd0};
    end else if (ea == '0 && fa == '0) begin
      s0_nxt.special = 1'b1;
      s0_nxt.spec_val = {sgn, 63'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (en) s0_vld_r <= in_fire;
    if (en) s0_r <= s0_nxt;
  end

  // ---- division stage chain ----
  div_item_t d_r [NStg+1];
  logic      v_r [NStg+1];
  logic      v_nxt [NStg];

  assign d_r[0] = s0_r;
  assign v_r[0] = s0_vld_r;

  for (genvar g = 0; g < NStg; g++) begin : g_stg
    // last stage develops only the bits left over, 63 in total
    localparam int StgBits = (g == NStg - 1) ? QuoW - (NStg - 1) * BitsPerStage
                                             : BitsPerStage;
    bdiv_stage #(.Bits(StgBits)) u_stg (
      .clk         (clk),
      .en          (en),
      .vld_in      (v_r[g]),
      .d_in        (d_r[g]),
      .vld_out_nxt (v_nxt[g]),
      .d_out_r     (d_r[g+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g+1] <= 1'b0;
      else if (en) v_r[g+1] <= v_nxt[g];
    end
  end

  // ---- final stage: sticky, round, pack ----
  logic [63:0] res_nxt, res_r;
  logic        res_vld_r;

  always_comb begin
    div_item_t f;
    logic [QuoW-1:0] q;
    logic [63:0] q64, half, sub, m;
    logic [6:0] sh;
    logic sticky;
    f = d_r[NStg];
    // nonzero remainder folds into sticky
    q = f.q;
    sticky = (f.rem != '0);
    q64 = {1'b0, q[QuoW-1:1], q[0] | sticky};
    sh = '0; half = '0; sub = '0; m = '0;
    if (f.special) begin
      res_nxt = f.spec_val;
    end else if (f.ez < 0) begin
      if (f.ez <= -13'sd54) begin
        res_nxt = {f.sgn, 63'd0};
      end else begin
        sh = 7'(13'sd10 - f.ez);
        half = 64'd1 << (sh - 7'd1);
        sub = (q64 + half) >> sh;
        if ((q64 & ((half << 1) - 64'd1)) == half) sub[0] = 1'b0;
        res_nxt = {f.sgn, 63'd0} | sub;
      end
    end else if (f.ez > EXP_TOP) begin
      res_nxt = {f.sgn, EXP_ONES, 52'd0};
    end else begin
      m = (q64 + 64'(HALF_LSB)) >> 10;
      if (q64[9:0] == HALF_LSB) m[0] = 1'b0;
      res_nxt = {f.sgn, 63'd0} | (({51'd0, f.ez} << 52) + m);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_vld_r <= 1'b0;
    else if (en) res_vld_r <= v_r[NStg];
    if (en) res_r <= res_nxt;
  end

  assign out_ch.valid = res_vld_r;
  assign out_ch.data = res_r;
endmodule
